>>> sv/steering_seek_flee_arrive_unit_defines.svh
// Assertion macros for the steering unit.
`ifndef STEERING_SEEK_FLEE_ARRIVE_UNIT_DEFINES_SVH
`define STEERING_SEEK_FLEE_ARRIVE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SFA_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("steering unit assertion failed");
`define SFA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("steering unit implication failed");
`else
`define SFA_ASSERT(name, clk, rstn, prop)
`define SFA_ASSERT_IMP(name, clk, rstn, ante, cons)
`endif
`endif

>>> sv/sfa_pkg.sv
// Shared constants and types of the steering unit.
`default_nettype none
package sfa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int W             = 32;  // signed Q16.16 word
  localparam int MAG_W         = 32;  // magnitude of a 33-bit difference
  localparam int SPD_W         = 31;  // speed and force registers

  localparam logic [1:0] CMD_SEEK   = 2'd0;
  localparam logic [1:0] CMD_FLEE   = 2'd1;
  localparam logic [1:0] CMD_ARRIVE = 2'd2;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_MAX_FORCE = 2'd1;
  localparam logic [1:0] REG_ARRIVE_R2 = 2'd2;

  localparam logic [SPD_W-1:0] MAX_SPEED_RST = SPD_W'(262144);
  localparam logic [SPD_W-1:0] MAX_FORCE_RST = SPD_W'(6554);
  localparam logic [W-1:0]     ARRIVE_R2_RST = W'(655360000);

  typedef struct packed {
    logic             slow;
    logic [1:0]       cmd;
    logic             negx;
    logic             negy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [W-1:0]     vx;
    logic [W-1:0]     vy;
  } sfa_front_t;

  typedef struct packed {
    logic         slow;
    logic         flee;
    logic         negx;
    logic         negy;
    logic [W-1:0] vx;
    logic [W-1:0] vy;
  } sfa_mid_t;

  typedef struct packed {
    logic        slow;
    logic        flee;
    logic        limit;
    logic [33:0] fx;
    logic [33:0] fy;
  } sfa_back_t;

endpackage
`default_nettype wire

>>> sv/steering_seek_flee_arrive_unit.sv
// Top level of the seek, flee and arrive steering unit.
`default_nettype none
`include "steering_seek_flee_arrive_unit_defines.svh"
// The unit takes one agent per transfer and returns one steering force per
// transfer, in the same order. A new item may be offered in every cycle;
// the sustained rate is one item per clock while the output side takes
// results. The pipeline depth is set by the chain of bit-serial stages,
// namely the speed divider, and in each of the two magnitude rescalers a
// square root and a divider that produce one result bit per stage. The
// whole pipeline moves forward together whenever the output register is
// empty or its result is being taken, so a stall on the output side holds
// every stage in place and the input side is not ready for that cycle.
// Configuration registers are to be written only while no item is in
// flight.
module steering_seek_flee_arrive_unit
  import sfa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [W-1:0] cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_x, target_y, loc_x, loc_y, vel_x, vel_y (lowest bits first)
  input  logic [6*W-1:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // steer_x, steer_y (lowest bits first)
  output logic [2*W-1:0] m_axis_tdata,
  // slowing
  output logic [0:0]   m_axis_tuser
);

  // Configuration registers.
  logic [SPD_W-1:0]   max_speed_q, max_force_q;
  logic [W-1:0]       arrive_r2_q;
  logic [2*SPD_W-1:0] mf_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MAX_SPEED_RST;
      max_force_q <= MAX_FORCE_RST;
      arrive_r2_q <= ARRIVE_R2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_SPEED: max_speed_q <= cfg_data_i[SPD_W-1:0];
        REG_MAX_FORCE: max_force_q <= cfg_data_i[SPD_W-1:0];
        REG_ARRIVE_R2: arrive_r2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The square of the force limit is static while items are in flight.
  always_ff @(posedge clk_i) begin
    mf_sq_q <= max_force_q * max_force_q;
  end

  // One enable moves every stage; it is low only when a result waits and
  // the sink is not taking it.
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 0: offsets to the target, exact in 33 bits.
  logic              v0_q;
  logic [1:0]        cmd0_q;
  logic signed [W:0] dx0_q, dy0_q;
  logic [W-1:0]      vx0_q, vy0_q;

  // Stage 1: magnitudes and their squares.
  logic               v1_q;
  logic [1:0]         cmd1_q;
  logic               negx1_q, negy1_q;
  logic [MAG_W-1:0]   ax1_q, ay1_q;
  logic [2*MAG_W-1:0] sqx1_q, sqy1_q;
  logic [W-1:0]       vx1_q, vy1_q;

  // Stage 2: squared distance, slowing decision, distance above the fraction.
  logic               v2_q;
  logic               slow2_q;
  logic [W-1:0]       shi2_q;
  sfa_front_t         fr2_q;

  // Stage 3: numerator of the reduced speed.
  logic               v3_q;
  logic [SPD_W+W-1:0] num3_q;
  sfa_front_t         fr3_q;

  logic [MAG_W-1:0]   ax1_d, ay1_d;
  logic [2*MAG_W:0]   dist_sq;
  logic               slow2_d;

  assign ax1_d   = MAG_W'(dx0_q[W] ? -dx0_q : dx0_q);
  assign ay1_d   = MAG_W'(dy0_q[W] ? -dy0_q : dy0_q);
  assign dist_sq = (2*MAG_W+1)'(sqx1_q) + (2*MAG_W+1)'(sqy1_q);
  // Arrive slows while the squared distance is below the squared radius;
  // a zero radius never slows.
  assign slow2_d = (cmd1_q == CMD_ARRIVE) &&
                   (dist_sq < ((2*MAG_W+1)'(arrive_r2_q) << FRAC_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q  <= s_axis_tuser;
      dx0_q   <= $signed({s_axis_tdata[W-1], s_axis_tdata[W-1:0]}) -
                 $signed({s_axis_tdata[3*W-1], s_axis_tdata[3*W-1:2*W]});
      dy0_q   <= $signed({s_axis_tdata[2*W-1], s_axis_tdata[2*W-1:W]}) -
                 $signed({s_axis_tdata[4*W-1], s_axis_tdata[4*W-1:3*W]});
      vx0_q   <= s_axis_tdata[5*W-1:4*W];
      vy0_q   <= s_axis_tdata[6*W-1:5*W];

      cmd1_q  <= cmd0_q;
      negx1_q <= dx0_q[W];
      negy1_q <= dy0_q[W];
      ax1_q   <= ax1_d;
      ay1_q   <= ay1_d;
      sqx1_q  <= ax1_d * ax1_d;
      sqy1_q  <= ay1_d * ay1_d;
      vx1_q   <= vx0_q;
      vy1_q   <= vy0_q;

      slow2_q    <= slow2_d;
      shi2_q     <= W'(dist_sq >> FRAC_BITS);
      fr2_q.slow <= slow2_d;
      fr2_q.cmd  <= cmd1_q;
      fr2_q.negx <= negx1_q;
      fr2_q.negy <= negy1_q;
      fr2_q.ax   <= ax1_q;
      fr2_q.ay   <= ay1_q;
      fr2_q.vx   <= vx1_q;
      fr2_q.vy   <= vy1_q;

      num3_q  <= max_speed_q * shi2_q;
      fr3_q   <= fr2_q;
    end
  end

  // Reduced speed: max_speed times the scaled squared distance over the squared radius.
  // When the item does not slow, the quotient is ignored.
  logic                  spd_vld;
  logic [0:0][SPD_W-1:0] spd_quo;
  sfa_front_t            spd_side;
  logic [SPD_W-1:0]      speed;
  sfa_mid_t              mid_in;

  sfa_div #(
    .NL (1),
    .VW (W),
    .QW (SPD_W),
    .SW ($bits(sfa_front_t))
  ) u_spd_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_i   (arrive_r2_q),
    .side_i  (fr3_q),
    .valid_o (spd_vld),
    .quo_o   (spd_quo),
    .side_o  (spd_side)
  );

  assign speed       = spd_side.slow ? spd_quo[0] : max_speed_q;
  assign mid_in.slow = spd_side.slow;
  assign mid_in.flee = (spd_side.cmd == CMD_FLEE);
  assign mid_in.negx = spd_side.negx;
  assign mid_in.negy = spd_side.negy;
  assign mid_in.vx   = spd_side.vx;
  assign mid_in.vy   = spd_side.vy;

  // Desired velocity: the offset rescaled to the chosen speed.
  logic             dv_vld;
  logic [SPD_W-1:0] dvx, dvy;
  sfa_mid_t         mid_out;

  sfa_mag #(
    .SW ($bits(sfa_mid_t))
  ) u_mag_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (spd_vld),
    .ax_i    (spd_side.ax),
    .ay_i    (spd_side.ay),
    .m_i     (speed),
    .side_i  (mid_in),
    .valid_o (dv_vld),
    .cx_o    (dvx),
    .cy_o    (dvy),
    .side_o  (mid_out)
  );

  // Stage 4: raw force, desired velocity less the current velocity.
  // Stage 5: its squared components. Stage 6: the limit decision.
  logic               v4_q, v5_q, v6_q;
  logic signed [33:0] fx_d, fy_d;
  logic signed [33:0] fx4_q, fy4_q, fx5_q, fy5_q;
  logic [MAG_W-1:0]   fxm4_q, fym4_q;
  logic [2*MAG_W-1:0] fsx5_q, fsy5_q;
  logic               slow4_q, flee4_q, slow5_q, flee5_q;
  logic [2*MAG_W:0]   force_sq;
  sfa_back_t          bk6_q;
  logic [MAG_W-1:0]   fxm6_q, fym6_q, fxm5_q, fym5_q;

  assign fx_d = (mid_out.negx ? -$signed({3'b000, dvx}) : $signed({3'b000, dvx})) -
                34'($signed(mid_out.vx));
  assign fy_d = (mid_out.negy ? -$signed({3'b000, dvy}) : $signed({3'b000, dvy})) -
                34'($signed(mid_out.vy));
  assign force_sq = (2*MAG_W+1)'(fsx5_q) + (2*MAG_W+1)'(fsy5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v4_q <= dv_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx4_q   <= fx_d;
      fy4_q   <= fy_d;
      fxm4_q  <= MAG_W'(fx_d[33] ? -fx_d : fx_d);
      fym4_q  <= MAG_W'(fy_d[33] ? -fy_d : fy_d);
      slow4_q <= mid_out.slow;
      flee4_q <= mid_out.flee;

      fsx5_q  <= fxm4_q * fxm4_q;
      fsy5_q  <= fym4_q * fym4_q;
      fxm5_q  <= fxm4_q;
      fym5_q  <= fym4_q;
      fx5_q   <= fx4_q;
      fy5_q   <= fy4_q;
      slow5_q <= slow4_q;
      flee5_q <= flee4_q;

      bk6_q.slow  <= slow5_q;
      bk6_q.flee  <= flee5_q;
      bk6_q.limit <= force_sq > (2*MAG_W+1)'(mf_sq_q);
      bk6_q.fx    <= fx5_q;
      bk6_q.fy    <= fy5_q;
      fxm6_q      <= fxm5_q;
      fym6_q      <= fym5_q;
    end
  end

  // Force limited to max_force, used only when the limit applies.
  logic             lf_vld;
  logic [SPD_W-1:0] lfx, lfy;
  sfa_back_t        bk_out;

  sfa_mag #(
    .SW ($bits(sfa_back_t))
  ) u_mag_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .ax_i    (fxm6_q),
    .ay_i    (fym6_q),
    .m_i     (max_force_q),
    .side_i  (bk6_q),
    .valid_o (lf_vld),
    .cx_o    (lfx),
    .cy_o    (lfy),
    .side_o  (bk_out)
  );

  // Output stage: pick the limited or raw force, negate for flee, saturate.
  logic signed [34:0] selx, sely, finx, finy;
  logic [W-1:0]       satx, saty;
  logic [W-1:0]       steer_x_q, steer_y_q;
  logic               slowing_q;

  always_comb begin
    if (bk_out.limit) begin
      selx = bk_out.fx[33] ? -$signed({4'b0000, lfx}) : $signed({4'b0000, lfx});
      sely = bk_out.fy[33] ? -$signed({4'b0000, lfy}) : $signed({4'b0000, lfy});
    end else begin
      selx = 35'($signed(bk_out.fx));
      sely = 35'($signed(bk_out.fy));
    end
    finx = bk_out.flee ? -selx : selx;
    finy = bk_out.flee ? -sely : sely;
    if (finx > 35'sd2147483647) begin
      satx = {1'b0, {(W-1){1'b1}}};
    end else if (finx < -35'sd2147483648) begin
      satx = {1'b1, {(W-1){1'b0}}};
    end else begin
      satx = finx[W-1:0];
    end
    if (finy > 35'sd2147483647) begin
      saty = {1'b0, {(W-1){1'b1}}};
    end else if (finy < -35'sd2147483648) begin
      saty = {1'b1, {(W-1){1'b0}}};
    end else begin
      saty = finy[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= lf_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      steer_x_q <= satx;
      steer_y_q <= saty;
      slowing_q <= bk_out.slow;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {steer_y_q, steer_x_q};
  assign m_axis_tuser  = slowing_q;

  // Items in flight, for the checks below.
  logic [7:0] inflight_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(s_axis_tvalid && s_axis_tready)
                               - 8'(m_axis_tvalid && m_axis_tready);
    end
  end

  // A result is only ever shown for an item that went in.
  `SFA_ASSERT_IMP(a_out_has_item, clk_i, rst_ni, m_axis_tvalid, inflight_q != 8'd0)
  // The reduced speed never exceeds the configured speed.
  `SFA_ASSERT_IMP(a_spd_bound, clk_i, rst_ni, spd_vld && spd_side.slow,
                  spd_quo[0] <= max_speed_q)
  // Rescaled desired velocity stays within the configured speed.
  `SFA_ASSERT_IMP(a_dv_bound, clk_i, rst_ni, dv_vld,
                  (dvx <= max_speed_q) && (dvy <= max_speed_q))
  // The limited force stays within the force limit.
  `SFA_ASSERT_IMP(a_force_bound, clk_i, rst_ni, lf_vld,
                  (lfx <= max_force_q) && (lfy <= max_force_q))

endmodule
`default_nettype wire

>>> sv/sfa_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
`default_nettype none
module sfa_div #(
  parameter int NL = 1,
  parameter int VW = 32,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [NL-1:0][QW+VW-1:0]      num_i,
  input  logic [VW-1:0]                 den_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [NL-1:0][QW-1:0]         quo_o,
  output logic [SW-1:0]                 side_o
);

  logic [QW:0]                vld_q;
  logic [NL-1:0][VW-1:0]      rem_q [QW+1];
  logic [NL-1:0][VW-1:0]      rem_d [QW+1];
  logic [NL-1:0][QW-1:0]      x_q   [QW+1];
  logic [NL-1:0][QW-1:0]      x_d   [QW+1];
  logic [VW-1:0]              den_q [QW+1];
  logic [SW-1:0]              side_q [QW+1];

  for (genvar l = 0; l < NL; l++) begin : g_in
    assign rem_d[0][l] = num_i[l][QW+VW-1:QW];
    assign x_d[0][l]   = num_i[l][QW-1:0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [VW:0] t;
      logic        ge;
      assign t  = {rem_q[k][l], x_q[k][l][QW-1]};
      assign ge = t >= {1'b0, den_q[k]};
      assign rem_d[k+1][l] = ge ? VW'(t - {1'b0, den_q[k]}) : t[VW-1:0];
      assign x_d[k+1][l]   = {x_q[k][l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QW; k++) begin
        rem_q[k] <= rem_d[k];
        x_q[k]   <= x_d[k];
      end
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 1; k <= QW; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = x_q[QW];
  assign side_o  = side_q[QW];

endmodule
`default_nettype wire

>>> sv/sfa_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module sfa_isqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW:0]     vld_q;
  logic [RW:0]     rem_q  [RW+1];
  logic [RW:0]     rem_d  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [RW-1:0]   root_d [RW+1];
  logic [2*RW-1:0] x_q    [RW+1];
  logic [2*RW-1:0] x_d    [RW+1];
  logic [SW-1:0]   side_q [RW+1];

  assign rem_d[0]  = '0;
  assign root_d[0] = '0;
  assign x_d[0]    = rad_i;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic          ge;
    assign t          = {rem_q[k], x_q[k][2*RW-1 -: 2]};
    assign trial      = {1'b0, root_q[k], 2'b01};
    assign ge         = t >= trial;
    assign rem_d[k+1]  = ge ? (RW+1)'(t - trial) : t[RW:0];
    assign root_d[k+1] = {root_q[k][RW-2:0], ge};
    assign x_d[k+1]    = {x_q[k][2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= RW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        x_q[k]    <= x_d[k];
      end
      side_q[0] <= side_i;
      for (int k = 1; k <= RW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = root_q[RW];
  assign side_o  = side_q[RW];

endmodule
`default_nettype wire

>>> sv/sfa_mag.sv
// Rescales a magnitude pair to a given length: square root, products, division.
`default_nettype none
module sfa_mag
  import sfa_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [MAG_W-1:0] ax_i,
  input  logic [MAG_W-1:0] ay_i,
  input  logic [SPD_W-1:0] m_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [SPD_W-1:0] cx_o,
  output logic [SPD_W-1:0] cy_o,
  output logic [SW-1:0]    side_o
);

  localparam int BW  = MAG_W - 1;
  localparam int NW  = SPD_W + MAG_W;
  localparam int ISW = 2*BW + SPD_W + SW;

  logic             shift;
  logic             va_q, vb_q, vd_q;
  logic [BW-1:0]    bx_a_q, by_a_q, bx_b_q, by_b_q;
  logic [SPD_W-1:0] m_a_q, m_b_q;
  logic [SW-1:0]    side_a_q, side_b_q, side_d_q;
  logic [2*BW-1:0]  sqx_b_q, sqy_b_q;
  logic             sq_vld;
  logic [MAG_W-1:0] root;
  logic [ISW-1:0]   sq_side;
  logic [BW-1:0]    bx_s, by_s;
  logic [SPD_W-1:0] m_s;
  logic [SW-1:0]    side_s;
  logic [NW-1:0]    px_d_q, py_d_q;
  logic [MAG_W-1:0] len_d_q;
  logic [1:0][SPD_W-1:0] quo;

  // Halve both magnitudes when either one reaches bit 31.
  assign shift = ax_i[MAG_W-1] | ay_i[MAG_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vd_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_a_q   <= BW'(ax_i >> shift);
      by_a_q   <= BW'(ay_i >> shift);
      m_a_q    <= m_i;
      side_a_q <= side_i;
      sqx_b_q  <= bx_a_q * bx_a_q;
      sqy_b_q  <= by_a_q * by_a_q;
      bx_b_q   <= bx_a_q;
      by_b_q   <= by_a_q;
      m_b_q    <= m_a_q;
      side_b_q <= side_a_q;
      px_d_q   <= NW'(bx_s * m_s);
      py_d_q   <= NW'(by_s * m_s);
      len_d_q  <= (root == '0) ? MAG_W'(1) : root;
      side_d_q <= side_s;
    end
  end

  sfa_isqrt #(
    .RW (MAG_W),
    .SW (ISW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vb_q),
    .rad_i   ((2*MAG_W)'(sqx_b_q) + (2*MAG_W)'(sqy_b_q)),
    .side_i  ({bx_b_q, by_b_q, m_b_q, side_b_q}),
    .valid_o (sq_vld),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign {bx_s, by_s, m_s, side_s} = sq_side;

  sfa_div #(
    .NL (2),
    .VW (MAG_W),
    .QW (SPD_W),
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vd_q),
    .num_i   ({py_d_q, px_d_q}),
    .den_i   (len_d_q),
    .side_i  (side_d_q),
    .valid_o (valid_o),
    .quo_o   (quo),
    .side_o  (side_o)
  );

  assign cx_o = quo[0];
  assign cy_o = quo[1];

endmodule
`default_nettype wire

>>> tb/steering_force_checker.sv
// Checker for the steering unit: watches the ports, predicts each force and compares.
`timescale 1ns / 100ps
module steering_force_checker
  import sfa_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [W-1:0]   cfg_data_i,
  input  logic           s_axis_tvalid,
  input  logic           s_axis_tready,
  input  logic [6*W-1:0] s_axis_tdata,
  input  logic [1:0]     s_axis_tuser,
  input  logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  input  logic [2*W-1:0] m_axis_tdata,
  input  logic [0:0]     m_axis_tuser,
  output int             mismatches_o,
  output int             pending_o,
  output int             forces_seen_o
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [W-1:0] steer_x;
    logic [W-1:0] steer_y;
    logic         slowing;
  } steer_force_t;

  steer_force_t force_q[$];

  logic [SPD_W-1:0] speed_reg;
  logic [SPD_W-1:0] force_reg;
  logic [W-1:0]     radius_sq_reg;

  function automatic u64_t int_sqrt(input u64_t q);
    u64_t r;
    u64_t b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > q) b = b >> 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q = q - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Squared length of two magnitudes below 2^32, with the carry out of bit 63.
  function automatic logic [64:0] length_sq(input u64_t ax, input u64_t ay);
    u64_t a2;
    u64_t b2;
    a2 = ax * ax;
    b2 = ay * ay;
    return {1'b0, a2} + {1'b0, b2};
  endfunction

  // Scales a magnitude pair to length m; each component is rounded toward zero.
  task automatic rescale(input u64_t ax, input u64_t ay, input u64_t m,
                         output u64_t ox, output u64_t oy);
    u64_t bx;
    u64_t by;
    u64_t len;
    if (ax == 0 && ay == 0) begin
      ox = 0;
      oy = 0;
    end else begin
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
        bx = ax >> 1;
        by = ay >> 1;
      end else begin
        bx = ax;
        by = ay;
      end
      len = int_sqrt(bx * bx + by * by);
      if (len == 0) len = 1;
      ox = bx * m / len;
      oy = by * m / len;
    end
  endtask

  function automatic logic [W-1:0] saturate(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[W-1:0];
  endfunction

  task automatic predict_force(input logic [1:0] cmd, input logic [6*W-1:0] agent,
                               output steer_force_t res);
    longint dx, dy, vx, vy, fx, fy;
    u64_t ax, ay, speed, mf, r2, cx, cy, fxm, fym;
    logic [64:0] s65;
    logic slow;
    dx = longint'($signed(agent[0*W +: W])) - longint'($signed(agent[2*W +: W]));
    dy = longint'($signed(agent[1*W +: W])) - longint'($signed(agent[3*W +: W]));
    vx = longint'($signed(agent[4*W +: W]));
    vy = longint'($signed(agent[5*W +: W]));
    ax = dx < 0 ? u64_t'(-dx) : u64_t'(dx);
    ay = dy < 0 ? u64_t'(-dy) : u64_t'(dy);
    speed = u64_t'(speed_reg);
    mf = u64_t'(force_reg);
    r2 = u64_t'(radius_sq_reg);
    slow = 1'b0;
    s65 = length_sq(ax, ay);
    // Inside the slowing radius the speed falls off linearly with squared distance.
    if (cmd == CMD_ARRIVE && !s65[64] && s65[63:0] < (r2 << 16)) begin
      slow = 1'b1;
      speed = speed * (s65[63:0] >> 16) / r2;
    end
    rescale(ax, ay, speed, cx, cy);
    fx = (dx < 0 ? -longint'(cx) : longint'(cx)) - vx;
    fy = (dy < 0 ? -longint'(cy) : longint'(cy)) - vy;
    fxm = fx < 0 ? u64_t'(-fx) : u64_t'(fx);
    fym = fy < 0 ? u64_t'(-fy) : u64_t'(fy);
    s65 = length_sq(fxm, fym);
    if (s65[64] || s65[63:0] > mf * mf) begin
      rescale(fxm, fym, mf, fxm, fym);
      fx = fx < 0 ? -longint'(fxm) : longint'(fxm);
      fy = fy < 0 ? -longint'(fym) : longint'(fym);
    end
    if (cmd == CMD_FLEE) begin
      fx = -fx;
      fy = -fy;
    end
    res.steer_x = saturate(fx);
    res.steer_y = saturate(fy);
    res.slowing = slow;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_force_t exp_f;
    steer_force_t got_f;
    if (!rst_ni) begin
      speed_reg <= MAX_SPEED_RST;
      force_reg <= MAX_FORCE_RST;
      radius_sq_reg <= ARRIVE_R2_RST;
      force_q.delete();
      mismatches_o = 0;
      pending_o = 0;
      forces_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_SPEED: speed_reg <= cfg_data_i[SPD_W-1:0];
          REG_MAX_FORCE: force_reg <= cfg_data_i[SPD_W-1:0];
          REG_ARRIVE_R2: radius_sq_reg <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_force(s_axis_tuser, s_axis_tdata, exp_f);
        force_q.push_back(exp_f);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_f.steer_x = m_axis_tdata[0 +: W];
        got_f.steer_y = m_axis_tdata[W +: W];
        got_f.slowing = m_axis_tuser[0];
        forces_seen_o++;
        if (force_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("unexpected force transfer: x=%h y=%h slowing=%b",
                     got_f.steer_x, got_f.steer_y, got_f.slowing);
        end else begin
          exp_f = force_q.pop_front();
          if (got_f !== exp_f) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("force mismatch: expected x=%h y=%h slowing=%b, got x=%h y=%h slowing=%b",
                       exp_f.steer_x, exp_f.steer_y, exp_f.slowing,
                       got_f.steer_x, got_f.steer_y, got_f.slowing);
          end
        end
      end
      pending_o = force_q.size();
    end
  end

endmodule

>>> tb/steering_seek_flee_arrive_unit_tb.sv
// Testbench top for the steering unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module steering_seek_flee_arrive_unit_tb;
  import sfa_pkg::*;

  // Generous ceiling on the run, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 600000;
  // Idle time after draining, with margin over the pipeline depth.
  localparam int SETTLE_CYCLES = 220;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [1:0]     cfg_idx_i;
  logic [W-1:0]   cfg_data_i;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [6*W-1:0] s_axis_tdata;  // target_x, target_y, loc_x, loc_y, vel_x, vel_y
  logic [1:0]     s_axis_tuser;  // command
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [2*W-1:0] m_axis_tdata;  // steer_x, steer_y
  logic [0:0]     m_axis_tuser;  // slowing

  int mismatches;
  int pending;
  int forces_seen;
  int cycles;
  int agents_sent;
  int settings_used;
  bit no_idle;
  bit output_held;

  steering_seek_flee_arrive_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  steering_force_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches_o(mismatches), .pending_o(pending), .forces_seen_o(forces_seen)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d forces still expected", cycles, pending);
        $display("steering_seek_flee_arrive_unit regression: fail");
        $finish;
      end
    end
  end

  // Offers one agent after a random gap and holds it until the transfer happens.
  // The valid is only lowered when a gap follows, so it never drops and rises
  // again within one time step.
  task automatic send_agent(input logic [1:0] cmd, input logic [W-1:0] tx,
                            input logic [W-1:0] ty, input logic [W-1:0] lx,
                            input logic [W-1:0] ly, input logic [W-1:0] vx,
                            input logic [W-1:0] vy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {vy, vx, ly, lx, ty, tx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    agents_sent++;
  endtask

  // Drops the valid and waits until every expected force has arrived, then
  // lets the pipeline run empty before any register may change.
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [W-1:0] speed, input logic [W-1:0] force_lim,
                                input logic [W-1:0] radius_sq);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_MAX_SPEED;
    cfg_data_i <= speed;
    @(negedge clk_i);
    cfg_idx_i <= REG_MAX_FORCE;
    cfg_data_i <= force_lim;
    @(negedge clk_i);
    cfg_idx_i <= REG_ARRIVE_R2;
    cfg_data_i <= radius_sq;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // A signed offset whose size is spread over many octaves, so that some
  // agents fall inside the slowing radius and others far outside it.
  function automatic logic [W-1:0] rand_offset();
    logic [W-1:0] m;
    m = W'($urandom_range(0, 2 ** $urandom_range(0, 26)));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [W-1:0] rand_velocity();
    return $urandom_range(0, 3) == 0 ? $urandom : rand_offset();
  endfunction

  // Mostly agents placed near their target with random content; a quarter
  // are pure noise across the full range of every field.
  task automatic send_random_agent();
    logic [W-1:0] lx, ly;
    logic [1:0] cmd;
    cmd = 2'($urandom_range(0, 3));
    lx = $urandom;
    ly = $urandom;
    if ($urandom_range(0, 3) == 0)
      send_agent(cmd, $urandom, $urandom, lx, ly, $urandom, $urandom);
    else
      send_agent(cmd, lx + rand_offset(), ly + rand_offset(), lx, ly,
                 rand_velocity(), rand_velocity());
  endtask

  task automatic send_random_batch(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random_agent();
    end
    no_idle = 1'b0;
  endtask

  // Output side: a random hold-off before each transfer, and once a long
  // stall so that the pipeline fills up and back-pressures the input.
  initial begin
    int gap;
    int taken;
    m_axis_tready = 1'b0;
    output_held = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken == 150 && !output_held) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        output_held = 1'b1;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    logic [W-1:0] big;
    logic [W-1:0] neg;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MAX_SPEED;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_SEEK;
    agents_sent = 0;
    settings_used = 0;
    no_idle = 1'b0;
    big = 32'h7FFF_FFFF;
    neg = 32'h8000_0000;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed agents under the reset settings: every command, including the
    // unused one that behaves as seek, a zero offset, and the field extremes.
    send_agent(CMD_SEEK, 32'h0001_0000, 0, 0, 0, 0, 0);
    send_agent(CMD_FLEE, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0);
    send_agent(CMD_ARRIVE, 32'h0005_0000, 32'h0003_0000, 0, 0, 0, 0);
    send_agent(CMD_ARRIVE, 32'h0100_0000, 0, 0, 0, 0, 0);
    send_agent(2'd3, 32'h0002_0000, 32'hFFFE_0000, 0, 0, 32'h0000_8000, 0);
    send_agent(CMD_SEEK, 32'h1234_0000, 32'h1234_0000, 32'h1234_0000, 32'h1234_0000,
               32'h0003_0000, 32'hFFFD_0000);
    send_agent(CMD_ARRIVE, 0, 0, 0, 0, 0, 0);
    send_agent(CMD_SEEK, big, big, neg, neg, neg, neg);
    send_agent(CMD_FLEE, neg, neg, big, big, big, big);
    send_agent(CMD_ARRIVE, big, neg, neg, big, big, neg);
    send_agent(CMD_FLEE, 0, 0, 0, 0, neg, neg);
    send_agent(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1);
    drain_pipeline();

    // Largest settings for the speed, the force limit and the squared radius.
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_agent(CMD_SEEK, big, big, neg, neg, 0, 0);
    send_agent(CMD_FLEE, neg, 0, big, 0, big, neg);
    send_agent(CMD_ARRIVE, 32'h0100_0000, 32'h0100_0000, 0, 0, neg, big);
    send_agent(CMD_ARRIVE, big, big, neg, neg, big, big);
    send_random_batch(60);
    drain_pipeline();

    // Zero radius means arrive never slows; zero speed and force give zero steering.
    write_settings(0, 0, 0);
    send_agent(CMD_ARRIVE, 0, 0, 0, 0, 0, 0);
    send_agent(CMD_ARRIVE, 32'h0000_0001, 0, 0, 0, big, neg);
    send_random_batch(40);
    drain_pipeline();

    write_settings(32'h0004_0000, 32'h7FFF_FFFF, 0);
    send_random_batch(40);
    drain_pipeline();

    // Random settings, mostly realistic speeds with a slowing radius in reach.
    for (int p = 0; p < 6; p++) begin
      write_settings($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000),
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000),
                     $urandom);
      send_random_batch(50);
      drain_pipeline();
    end

    $display("covered %0d agents and %0d forces over %0d register settings,",
             agents_sent, forces_seen, settings_used + 1);
    $display("with random gaps on both sides and one long output stall");
    if (mismatches == 0) begin
      $display("steering_seek_flee_arrive_unit regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("steering_seek_flee_arrive_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/sfa_pkg.sv
sv/sfa_div.sv
sv/sfa_isqrt.sv
sv/sfa_mag.sv
sv/steering_seek_flee_arrive_unit.sv
tb/steering_force_checker.sv
tb/steering_seek_flee_arrive_unit_tb.sv
